// ===== hw/rtl/stta_pkg.sv =====
// Package for the service table with lifetime aging.
// Holds the action and status codes, field widths and the cell data record.
// No dependencies.
package stta_pkg;

	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W = 7;
	localparam int LIFE_W = 33;
	localparam int WARN_W = 32;
	localparam int IP_W = 32;
	localparam int PORT_W = 16;
	localparam int TTL_W = 32;
	localparam int TICK_W = 16;
	localparam int GRACE_W = 16;
	localparam int REMOVED_W = 8;
	localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd300;
	localparam int WARN_NUM = 9;
	localparam int WARN_DEN = 10;

	localparam logic [ACTION_W-1:0] ACT_ANNOUNCE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NEW = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE = 3'd4;

	// Per-slot aging state that circulates through the ring of cells.
	typedef struct packed {
		logic              valid;
		logic [LIFE_W-1:0] life;
		logic [WARN_W-1:0] warn;
	} age_t;

	// Operation broadcast from the controller to every cell.
	typedef struct packed {
		logic              shift;
		logic              tick;
		logic              write;
		logic [TICK_W-1:0] amount;
		logic [LIFE_W-1:0] new_life;
		logic [WARN_W-1:0] new_warn;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/service_table_with_ttl_aging.sv =====
// Service table with lifetime aging: top level, controller and payload memories.
// Depends on stta_pkg and stta_chain.
//
// Each transaction on s_axis yields one result on m_axis, and no new transaction
// is taken until that result has been accepted. The aging state of all slots
// sits in a ring of cells that rotates one step per cycle while a scan or read
// runs. An announce scans every slot, finishes the delayed key compare at the
// end of the scan and then updates the slot in the write state; a tick scans
// every slot. A read rotates the ring until the requested slot sits in the head
// cell and then reads it out. A rejected announce or an unknown action answers
// in the cycle after acceptance. Key, address and port live in memories; the
// valid bits live in the ring, so a slot's physical position is tracked by a
// rotation offset.
module service_table_with_ttl_aging #(
	parameter int ENTRIES = 128,
	parameter int KEY_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata from bit 0: device_key(64) record_ttl(32) ipv4_address(32)
	// service_port(16) tick_amount(16) send_enabled(1) force_send(1) entry_index(7)
	input  logic [175:0] s_axis_tdata,
	// tuser from bit 0: action(2)
	input  logic [stta_pkg::ACTION_W-1:0] s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata from bit 0: status(3) slot(7) send_query(1) removed_count(8)
	// entry_valid(1) entry_key(64) entry_ip(32) entry_port(16)
	// entry_lifetime_left(32)
	output logic [167:0] m_axis_tdata
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES+1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_READ, S_READ2, S_OUT} state_t;

	state_t state_q;
	logic [stta_pkg::GRACE_W-1:0] grace_q;
	logic [stta_pkg::ACTION_W-1:0] act_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [stta_pkg::TTL_W-1:0] ttl_q;
	logic [stta_pkg::IP_W-1:0] ip_q;
	logic [stta_pkg::PORT_W-1:0] port_q;
	logic [stta_pkg::TICK_W-1:0] tick_q;
	logic send_q, force_q;
	logic [6:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rot_q;
	logic match_f_q, free_f_q, exp_any_q;
	logic [IW-1:0] match_q, free_q;
	logic [stta_pkg::REMOVED_W-1:0] removed_q;
	logic [stta_pkg::LIFE_W-1:0] nlife_q;
	logic [stta_pkg::WARN_W-1:0] quot_q;
	logic [stta_pkg::WARN_W-1:0] warn_rem;
	logic [stta_pkg::WARN_W-1:0] nwarn_q;
	logic [167:0] out_q;
	logic [CW-1:0] wr_pos;
	stta_pkg::cell_cmd_t cmd;
	stta_pkg::age_t head;
	logic head_warn, head_expire;

	logic [KEY_WIDTH-1:0] key_mem [ENTRIES];
	logic [stta_pkg::IP_W-1:0] ip_mem [ENTRIES];
	logic [stta_pkg::PORT_W-1:0] port_mem [ENTRIES];
	logic [KEY_WIDTH-1:0] key_rd_q;
	logic [stta_pkg::IP_W-1:0] ip_rd_q;
	logic [stta_pkg::PORT_W-1:0] port_rd_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] head_slot;
	logic [IW-1:0] tgt;
	logic [IW-1:0] rd_slot;
	logic [stta_pkg::LIFE_W-1:0] rd_life;

	// Input field views.
	logic [stta_pkg::ACTION_W-1:0] in_act;
	assign in_act = s_axis_tuser;

	// Slot held at a ring position: each step moves every slot one position
	// up, so after rot_q steps slot s sits at position (s+rot) mod ENTRIES.
	// The last cell holds slot (ENTRIES-1-rot) mod ENTRIES, and during a scan
	// the head steps down by one slot per cycle.
	function automatic logic [IW-1:0] slot_of_pos(input logic [IW-1:0] pos,
			input logic [IW-1:0] rot);
		logic [IW:0] s;
		s = {1'b0, pos} + (IW+1)'(ENTRIES) - {1'b0, rot};
		if (s >= (IW+1)'(ENTRIES)) s = s - (IW+1)'(ENTRIES);
		return s[IW-1:0];
	endfunction

	// Position of a slot in the ring given the rotation.
	function automatic logic [IW-1:0] pos_of_slot(input logic [IW-1:0] sl,
			input logic [IW-1:0] rot);
		logic [IW:0] s;
		s = {1'b0, sl} + {1'b0, rot};
		if (s >= (IW+1)'(ENTRIES)) s = s - (IW+1)'(ENTRIES);
		return s[IW-1:0];
	endfunction

	// The head cell (position ENTRIES-1) holds this slot.
	assign head_slot = slot_of_pos(IW'(ENTRIES-1), rot_q);
	assign tgt = match_f_q ? match_q : free_q;
	assign rd_slot = (int'(idx_q) >= ENTRIES) ? '0 : IW'(idx_q);
	assign rd_addr = (state_q == S_READ) ? rd_slot : tgt;

	// Remainder of ttl divided by ten, from the registered quotient.
	assign warn_rem = ttl_q - quot_q * 32'(stta_pkg::WARN_DEN);

	always_comb begin
		cmd = '0;
		cmd.amount = (act_q == stta_pkg::ACT_TICK) ? tick_q : '0;
		cmd.new_life = nlife_q;
		cmd.new_warn = nwarn_q;
		cmd.shift = (state_q == S_SCAN && cnt_q != CW'(ENTRIES))
			|| (state_q == S_READ && head_slot != rd_slot);
		cmd.tick = (state_q == S_SCAN) && (cnt_q != CW'(ENTRIES))
			&& (act_q == stta_pkg::ACT_TICK);
		cmd.write = (state_q == S_WRITE);
	end
	assign wr_pos = {1'b0, pos_of_slot(tgt, rot_q)};

	stta_chain #(.ENTRIES(ENTRIES)) u_chain (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .wr_pos(wr_pos),
		.head(head), .head_warn(head_warn), .head_expire(head_expire)
	);

	assign rd_life = head.life;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = out_q;

	// Payload memories: written on an announce, read for reads and matching.
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			key_mem[tgt] <= key_q;
			ip_mem[tgt] <= ip_q;
			port_mem[tgt] <= port_q;
		end
		key_rd_q <= key_mem[(state_q == S_SCAN) ? head_slot : rd_addr];
		ip_rd_q <= ip_mem[rd_addr];
		port_rd_q <= port_mem[rd_addr];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grace_q <= stta_pkg::GRACE_RESET;
		else if (cfg_we) grace_q <= cfg_wdata;
	end

	// Controller: scans rotate the ring once, a read rotates it to the slot.
	// The key compare uses the key memory read, registered behind the head,
	// so the valid bit of that slot is registered alongside. The scan does not
	// visit slots in ascending order, so the lowest matching or free slot
	// is kept.
	logic scan_v_q;
	logic [IW-1:0] scan_slot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rot_q <= '0;
			cnt_q <= '0;
			out_q <= '0;
			scan_v_q <= 1'b0;
		end else begin
			case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					act_q <= in_act;
					key_q <= s_axis_tdata[0 +: KEY_WIDTH];
					ttl_q <= s_axis_tdata[64 +: 32];
					ip_q <= s_axis_tdata[96 +: 32];
					port_q <= s_axis_tdata[128 +: 16];
					tick_q <= s_axis_tdata[144 +: 16];
					send_q <= s_axis_tdata[160];
					force_q <= s_axis_tdata[161];
					idx_q <= s_axis_tdata[162 +: 7];
					match_f_q <= 1'b0;
					free_f_q <= 1'b0;
					exp_any_q <= 1'b0;
					removed_q <= '0;
					scan_v_q <= 1'b0;
					cnt_q <= '0;
					nlife_q <= {1'b0, s_axis_tdata[64 +: 32]} + stta_pkg::LIFE_W'(grace_q);
					out_q <= '0;
					case (in_act)
					stta_pkg::ACT_ANNOUNCE: begin
						if (s_axis_tdata[64 +: 32] == '0 || s_axis_tdata[128 +: 16] == '0) begin
							out_q[2:0] <= stta_pkg::ST_REJECTED;
							state_q <= S_OUT;
						end else state_q <= S_SCAN;
					end
					stta_pkg::ACT_TICK: state_q <= S_SCAN;
					stta_pkg::ACT_READ: state_q <= S_READ;
					default: begin
						out_q[2:0] <= stta_pkg::ST_DONE;
						state_q <= S_OUT;
					end
					endcase
				end
			end
			S_SCAN: begin
				if (cnt_q != CW'(ENTRIES)) begin
					// Each cycle the head slot moves into cell zero.
					rot_q <= (rot_q == IW'(ENTRIES-1)) ? '0 : rot_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					scan_v_q <= head.valid;
					scan_slot_q <= head_slot;
					if (act_q == stta_pkg::ACT_TICK) begin
						if (head_warn) exp_any_q <= 1'b1;
						if (head_expire && removed_q != '1) removed_q <= removed_q + 1'b1;
					end else begin
						if (!head.valid && (!free_f_q || head_slot < free_q)) begin
							free_f_q <= 1'b1;
							free_q <= head_slot;
						end
					end
				end else begin
					if (act_q == stta_pkg::ACT_TICK) begin
						out_q[2:0] <= stta_pkg::ST_DONE;
						out_q[10] <= send_q && (exp_any_q || force_q);
						out_q[18:11] <= removed_q;
						state_q <= S_OUT;
					end else if (!match_f_q && !(scan_v_q && key_rd_q == key_q)
							&& !free_f_q) begin
						out_q[2:0] <= stta_pkg::ST_FULL;
						state_q <= S_OUT;
					end else state_q <= S_WRITE;
				end
				// Delayed key compare for the slot seen last cycle.
				if (act_q == stta_pkg::ACT_ANNOUNCE && cnt_q != '0 && scan_v_q
						&& key_rd_q == key_q && (!match_f_q || scan_slot_q < match_q)) begin
					match_f_q <= 1'b1;
					match_q <= scan_slot_q;
				end
				// Warning count ttl*9/10 as 9*q plus the share of the remainder,
				// where q = ttl/10 comes from a registered reciprocal multiply.
				quot_q <= 32'(({32'd0, ttl_q} * 64'd3435973837) >> 35);
				nwarn_q <= quot_q * 32'(stta_pkg::WARN_NUM)
					+ ((warn_rem != '0) ? warn_rem - 1'b1 : '0);
			end
			S_WRITE: begin
				out_q[2:0] <= match_f_q ? stta_pkg::ST_UPDATED : stta_pkg::ST_NEW;
				out_q[9:3] <= 7'(tgt);
				state_q <= S_OUT;
			end
			S_READ: begin
				// Rotate until the requested slot sits in the head cell.
				if (head_slot == rd_slot) begin
					state_q <= S_READ2;
				end else begin
					rot_q <= (rot_q == IW'(ENTRIES-1)) ? '0 : rot_q + 1'b1;
				end
			end
			S_READ2: begin
				out_q[2:0] <= stta_pkg::ST_DONE;
				out_q[9:3] <= 7'(rd_slot);
				if (head.valid) begin
					out_q[19] <= 1'b1;
					out_q[20 +: 64] <= 64'(key_rd_q);
					out_q[84 +: 32] <= ip_rd_q;
					out_q[116 +: 16] <= port_rd_q;
					out_q[132 +: 32] <= rd_life[32] ? 32'hFFFF_FFFF : rd_life[31:0];
				end
				state_q <= S_OUT;
			end
			S_OUT: if (m_axis_tready) state_q <= S_IDLE;
			default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/stta_cell.sv =====
// One aging cell of the ring: holds one slot's valid, lifetime and warning.
// Depends on stta_pkg.
module stta_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stta_pkg::cell_cmd_t cmd,
	input  logic               sel,
	input  stta_pkg::age_t     prev,
	output stta_pkg::age_t     cur,
	output stta_pkg::age_t     aged,
	output logic               warn_hit,
	output logic               expire
);

	stta_pkg::age_t age_q;

	assign cur = age_q;

	// Count down by the tick amount; report warnings and expiry.
	always_comb begin
		aged = age_q;
		warn_hit = 1'b0;
		expire = 1'b0;
		if (age_q.valid) begin
			if (age_q.warn != '0) begin
				if (age_q.warn <= {{(stta_pkg::WARN_W-stta_pkg::TICK_W){1'b0}}, cmd.amount}) begin
					warn_hit = 1'b1;
					aged.warn = '0;
				end else begin
					aged.warn = age_q.warn - {{(stta_pkg::WARN_W-stta_pkg::TICK_W){1'b0}}, cmd.amount};
				end
			end
			if (age_q.life <= {{(stta_pkg::LIFE_W-stta_pkg::TICK_W){1'b0}}, cmd.amount}) begin
				expire = 1'b1;
				aged = '0;
			end else begin
				aged.life = age_q.life - {{(stta_pkg::LIFE_W-stta_pkg::TICK_W){1'b0}}, cmd.amount};
			end
		end
	end

	// Rotate with the ring (cell zero takes the aged head during a tick), or take a new entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (cmd.write && sel) begin
			age_q.valid <= 1'b1;
			age_q.life <= cmd.new_life;
			age_q.warn <= cmd.new_warn;
		end else if (cmd.shift) begin
			age_q <= prev;
		end
	end

endmodule

// ===== hw/rtl/stta_chain.sv =====
// Ring of aging cells; the head cell's output is aged on each step of a tick.
// Depends on stta_pkg and stta_cell.
module stta_chain #(
	parameter int ENTRIES = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stta_pkg::cell_cmd_t cmd,
	input  logic [$clog2(ENTRIES+1)-1:0] wr_pos,
	output stta_pkg::age_t      head,
	output logic                head_warn,
	output logic                head_expire
);

	stta_pkg::age_t cur [ENTRIES];
	stta_pkg::age_t aged_v [ENTRIES];
	logic warn_v [ENTRIES];
	logic exp_v [ENTRIES];

	assign head = cur[ENTRIES-1];
	assign head_warn = warn_v[ENTRIES-1];
	assign head_expire = exp_v[ENTRIES-1];

	// The aged copy of the last cell is fed back to cell zero during a tick.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		stta_pkg::age_t prev;
		if (g == 0) begin : g_first
			assign prev = cmd.tick ? aged_v[ENTRIES-1] : cur[ENTRIES-1];
		end else begin : g_rest
			assign prev = cur[g-1];
		end
		stta_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.sel(wr_pos[$clog2(ENTRIES+1)-1:0] == ($clog2(ENTRIES+1))'(g)),
			.prev(prev), .cur(cur[g]), .aged(aged_v[g]), .warn_hit(warn_v[g]),
			.expire(exp_v[g])
		);
	end

endmodule

// ===== tb/service_table_with_ttl_aging_tb.sv =====
// Testbench for the service table with lifetime aging.
// Drives announce, tick and read transactions and checks every result against an in-bench table.
// Depends on stta_pkg and service_table_with_ttl_aging.
module service_table_with_ttl_aging_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = 128;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [1:0] ACT_INVALID = 2'd3;

	typedef struct {
		logic [1:0]  action;
		logic [63:0] key;
		logic [31:0] ttl;
		logic [31:0] ip;
		logic [15:0] port;
		logic [15:0] tick;
		logic        send_en;
		logic        force_q;
		logic [6:0]  idx;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  slot;
		logic        query;
		logic [7:0]  removed;
		logic        valid;
		logic [63:0] key;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] life;
	} answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [167:0] m_axis_tdata;

	// Shadow copy of the table and the grace register.
	logic        tbl_valid [NSLOTS];
	logic [63:0] tbl_key [NSLOTS];
	logic [31:0] tbl_ip [NSLOTS];
	logic [15:0] tbl_port [NSLOTS];
	logic [32:0] tbl_life [NSLOTS];
	logic [31:0] tbl_warn [NSLOTS];
	logic [15:0] grace;

	answer_t pending_answers[$];
	int      mismatches = 0;
	int      cycles = 0;
	int      rx_stall = 0;
	bit      no_gaps = 0;
	logic [63:0] key_pool [16];

	service_table_with_ttl_aging uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Computes the result of one transaction and updates the shadow table.
	function automatic answer_t table_apply(request_t rq);
		answer_t a;
		int match;
		int free_slot;
		int target;
		logic hit_warn;
		int removed;
		a = '{status: stta_pkg::ST_DONE, default: '0};
		if (rq.action == stta_pkg::ACT_ANNOUNCE) begin
			if (rq.ttl == 0 || rq.port == 0) begin
				a.status = stta_pkg::ST_REJECTED;
				return a;
			end
			match = -1;
			free_slot = -1;
			for (int i = 0; i < NSLOTS; i++) begin
				if (tbl_valid[i]) begin
					if (match < 0 && tbl_key[i] == rq.key)
						match = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (match < 0 && free_slot < 0) begin
				a.status = stta_pkg::ST_FULL;
				return a;
			end
			target = (match >= 0) ? match : free_slot;
			tbl_valid[target] = 1'b1;
			tbl_key[target] = rq.key;
			tbl_ip[target] = rq.ip;
			tbl_port[target] = rq.port;
			tbl_life[target] = {1'b0, rq.ttl} + {17'd0, grace};
			tbl_warn[target] = 32'(({32'd0, rq.ttl} * 64'd9) / 64'd10);
			a.status = (match >= 0) ? stta_pkg::ST_UPDATED : stta_pkg::ST_NEW;
			a.slot = 7'(target);
		end else if (rq.action == stta_pkg::ACT_TICK) begin
			hit_warn = 1'b0;
			removed = 0;
			for (int i = 0; i < NSLOTS; i++) begin
				if (!tbl_valid[i])
					continue;
				if (tbl_warn[i] != 0) begin
					if (tbl_warn[i] <= {16'd0, rq.tick}) begin
						hit_warn = 1'b1;
						tbl_warn[i] = '0;
					end else begin
						tbl_warn[i] = tbl_warn[i] - {16'd0, rq.tick};
					end
				end
				if (tbl_life[i] <= {17'd0, rq.tick}) begin
					tbl_valid[i] = 1'b0;
					tbl_key[i] = '0;
					tbl_ip[i] = '0;
					tbl_port[i] = '0;
					tbl_life[i] = '0;
					tbl_warn[i] = '0;
					if (removed < 255)
						removed++;
				end else begin
					tbl_life[i] = tbl_life[i] - {17'd0, rq.tick};
				end
			end
			a.query = rq.send_en && (hit_warn || rq.force_q);
			a.removed = 8'(removed);
		end else if (rq.action == stta_pkg::ACT_READ) begin
			a.slot = rq.idx;
			if (tbl_valid[rq.idx]) begin
				a.valid = 1'b1;
				a.key = tbl_key[rq.idx];
				a.ip = tbl_ip[rq.idx];
				a.port = tbl_port[rq.idx];
				a.life = tbl_life[rq.idx][32] ? 32'hFFFF_FFFF : tbl_life[rq.idx][31:0];
			end
		end
		return a;
	endfunction

	// Sends one transaction after a random gap; valid stays high for a back-to-back item.
	task automatic send_request(request_t rq);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, rq.idx, rq.force_q, rq.send_en, rq.tick, rq.port, rq.ip,
			rq.ttl, rq.key};
		s_axis_tuser <= rq.action;
		do @(posedge clk); while (!s_axis_tready);
		pending_answers.push_back(table_apply(rq));
	endtask

	// Lets the block drain before a register write.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_grace(logic [15:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		grace = value;
	endtask

	// Builds a request with every field random, then sets the ones that matter.
	function automatic request_t random_fill(logic [1:0] action);
		request_t rq;
		rq.action = action;
		rq.key = {$urandom, $urandom};
		rq.ttl = $urandom;
		rq.ip = $urandom;
		rq.port = 16'($urandom);
		rq.tick = 16'($urandom);
		rq.send_en = 1'($urandom);
		rq.force_q = 1'($urandom);
		rq.idx = 7'($urandom);
		return rq;
	endfunction

	task automatic do_announce(logic [63:0] key, logic [31:0] ttl, logic [31:0] ip,
		logic [15:0] port);
		request_t rq;
		rq = random_fill(stta_pkg::ACT_ANNOUNCE);
		rq.key = key;
		rq.ttl = ttl;
		rq.ip = ip;
		rq.port = port;
		send_request(rq);
	endtask

	task automatic do_tick(logic [15:0] amount, logic send_en, logic force_q);
		request_t rq;
		rq = random_fill(stta_pkg::ACT_TICK);
		rq.tick = amount;
		rq.send_en = send_en;
		rq.force_q = force_q;
		send_request(rq);
	endtask

	task automatic do_read(logic [6:0] idx);
		request_t rq;
		rq = random_fill(stta_pkg::ACT_READ);
		rq.idx = idx;
		send_request(rq);
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
		mismatches++;
	endtask

	// Receiver stalls.
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_axis_tready <= 1'b1;
			rx_stall <= gap_len();
		end
	end

	// Result checker: each transaction on the output is compared with the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
			end else begin
				want = pending_answers.pop_front();
				if (m_axis_tdata[2:0] !== want.status)
					report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
				if (m_axis_tdata[9:3] !== want.slot)
					report_mismatch("slot", 64'(m_axis_tdata[9:3]), 64'(want.slot));
				if (m_axis_tdata[10] !== want.query)
					report_mismatch("send_query", 64'(m_axis_tdata[10]), 64'(want.query));
				if (m_axis_tdata[18:11] !== want.removed)
					report_mismatch("removed_count", 64'(m_axis_tdata[18:11]),
						64'(want.removed));
				if (m_axis_tdata[19] !== want.valid)
					report_mismatch("entry_valid", 64'(m_axis_tdata[19]), 64'(want.valid));
				if (m_axis_tdata[83:20] !== want.key)
					report_mismatch("entry_key", m_axis_tdata[83:20], want.key);
				if (m_axis_tdata[115:84] !== want.ip)
					report_mismatch("entry_ip", 64'(m_axis_tdata[115:84]), 64'(want.ip));
				if (m_axis_tdata[131:116] !== want.port)
					report_mismatch("entry_port", 64'(m_axis_tdata[131:116]), 64'(want.port));
				if (m_axis_tdata[163:132] !== want.life)
					report_mismatch("entry_lifetime_left", 64'(m_axis_tdata[163:132]),
						64'(want.life));
				if (m_axis_tdata[167:164] !== 4'd0)
					report_mismatch("padding", 64'(m_axis_tdata[167:164]), 64'd0);
			end
		end
	end

	// Extreme announces, rejects, updates and reads.
	task automatic test_announce_corners();
		do_read(7'd0);
		do_announce(64'd0, 32'd1, 32'd0, 16'd1);
		do_announce(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		do_announce(64'h1234, 32'd0, 32'h0A00_0001, 16'd80);
		do_announce(64'h1234, 32'd100, 32'h0A00_0001, 16'd0);
		do_announce(64'h1234, 32'd1000, 32'h0A00_0001, 16'd80);
		do_announce(64'h1234, 32'd20, 32'hC0A8_0001, 16'd8080);
		do_read(7'd0);
		do_read(7'd1);
		do_read(7'd2);
		do_read(7'd127);
	endtask

	// Ticks with every query gating combination, warnings, expiry and unknown actions.
	task automatic test_tick_corners();
		request_t rq;
		do_tick(16'd0, 1'b1, 1'b0);
		do_tick(16'd0, 1'b1, 1'b1);
		do_tick(16'd0, 1'b0, 1'b1);
		do_tick(16'd17, 1'b1, 1'b0);
		do_tick(16'd1, 1'b1, 1'b0);
		do_tick(16'd1, 1'b0, 1'b0);
		do_read(7'd2);
		do_tick(16'd400, 1'b1, 1'b0);
		do_read(7'd1);
		do_tick(16'hFFFF, 1'b1, 1'b1);
		do_read(7'd1);
		rq = random_fill(ACT_INVALID);
		send_request(rq);
		rq = random_fill(ACT_INVALID);
		send_request(rq);
	endtask

	// Fills every slot, then announces a new key, updates an old one and clears all.
	task automatic test_table_full();
		for (int i = 0; i < NSLOTS; i++)
			do_announce(64'h5A00_0000_0000_0000 | 64'(i), 32'd50, $urandom, 16'd1 + 16'(i));
		do_announce(64'hDEAD_BEEF, 32'd50, 32'd1, 16'd1);
		do_announce(64'h5A00_0000_0000_0007, 32'd60, 32'd7, 16'd7);
		do_read(7'd7);
		do_read(7'd127);
		do_tick(16'd44, 1'b1, 1'b0);
		do_tick(16'hFFFF, 1'b1, 1'b0);
		do_read(7'd7);
	endtask

	// Random traffic drawn from a small key pool so that updates and expiries happen often.
	task automatic test_random_traffic(int count);
		request_t rq;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				rq = random_fill(stta_pkg::ACT_ANNOUNCE);
				if ($urandom_range(0, 9) < 8)
					rq.key = key_pool[$urandom_range(0, 15)];
				r = $urandom_range(0, 19);
				if (r == 0)
					rq.ttl = 32'd0;
				else if (r == 1)
					rq.port = 16'd0;
				else if (r == 2)
					rq.ttl = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
				else if (r < 17)
					rq.ttl = $urandom_range(1, 3000);
			end else if (r < 75) begin
				rq = random_fill(stta_pkg::ACT_TICK);
				if ($urandom_range(0, 9) < 8)
					rq.tick = $urandom_range(0, 400);
			end else if (r < 95) begin
				rq = random_fill(stta_pkg::ACT_READ);
				if ($urandom_range(0, 3) != 0)
					rq.idx = $urandom_range(0, 20);
			end else begin
				rq = random_fill(ACT_INVALID);
			end
			send_request(rq);
		end
	endtask

	initial begin
		for (int i = 0; i < NSLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_ip[i] = '0;
			tbl_port[i] = '0;
			tbl_life[i] = '0;
			tbl_warn[i] = '0;
		end
		grace = stta_pkg::GRACE_RESET;
		for (int i = 0; i < 16; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_announce_corners();
		test_tick_corners();
		write_grace(16'd0);
		test_announce_corners();
		write_grace(stta_pkg::GRACE_RESET);
		test_table_full();
		write_grace(16'd300);
		test_random_traffic(60);
		write_grace(16'd0);
		no_gaps = 1;
		test_random_traffic(50);
		no_gaps = 0;
		write_grace(16'hFFFF);
		test_random_traffic(60);
		write_grace(16'($urandom_range(1, 1000)));
		test_random_traffic(60);

		wait_idle();
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
